FILE: src/zbtr_pkg.sv
`default_nettype none
package zbtr_pkg;

    localparam int COLUMNS_DEF         = 80;
    localparam int ROWS_DEF            = 22;
    localparam int ANGLE_FRAC_BITS_DEF = 14;
    localparam int DEPTH_FRAC_BITS_DEF = 16;

    localparam int X_CENTER    = 40;
    localparam int X_SCALE     = 30;
    localparam int Y_CENTER    = 12;
    localparam int Y_SCALE     = 15;
    localparam int VIEW_DIST   = 5;
    localparam int SHADE_SCALE = 8;
    localparam int SHADE_MAX   = 11;
    localparam int TUBE_OFFSET = 2;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_PLOT  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [1:0] CFG_ROT_A_COS = 2'd0;
    localparam logic [1:0] CFG_ROT_A_SIN = 2'd1;
    localparam logic [1:0] CFG_ROT_B_COS = 2'd2;
    localparam logic [1:0] CFG_ROT_B_SIN = 2'd3;

    localparam logic [6:0] CHAR_NONE    = 7'd0;
    localparam logic [6:0] CHAR_NEWLINE = 7'd10;
    localparam logic [6:0] CHAR_SPACE   = 7'd32;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] tube_cos;
        logic [15:0] tube_sin;
        logic [15:0] ring_cos;
        logic [15:0] ring_sin;
        logic [10:0] cell_index;
    } t_in_item;

    typedef struct packed {
        logic [6:0] char_code;
        logic       plotted;
    } t_out_item;

    function automatic logic [6:0] shade_char(input logic [3:0] shade);
        logic [6:0] c;
        case (shade)
            4'd0:    c = 7'h2E;
            4'd1:    c = 7'h2C;
            4'd2:    c = 7'h2D;
            4'd3:    c = 7'h7E;
            4'd4:    c = 7'h3A;
            4'd5:    c = 7'h3B;
            4'd6:    c = 7'h3D;
            4'd7:    c = 7'h21;
            4'd8:    c = 7'h2A;
            4'd9:    c = 7'h23;
            4'd10:   c = 7'h24;
            4'd11:   c = 7'h40;
            default: c = 7'h40;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: src/zbuffer_torus_point_renderer.sv
`default_nettype none
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_in_item  (zbtr_pkg::t_in_item)
// output    out        o_out_valid / i_out_stall  o_out_item (zbtr_pkg::t_out_item)
// config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// Plot: multiplier products, then a depth divide, then position, z-buffer compare and the result.
// Read: a reciprocal multiply for the row, then the character. Mode 3 goes straight to the result.
// Clear: a memory sweep over all COLUMNS*ROWS entries at one entry a cycle, then the result.
// After reset the same sweep runs before the first item is taken.
// Each item ends in the idle state before the next is taken; a result waits in the output
// register while the next item runs, and a new result holds until that register is free.
module zbuffer_torus_point_renderer #(
    parameter int COLUMNS         = zbtr_pkg::COLUMNS_DEF,
    parameter int ROWS            = zbtr_pkg::ROWS_DEF,
    parameter int ANGLE_FRAC_BITS = zbtr_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int DEPTH_FRAC_BITS = zbtr_pkg::DEPTH_FRAC_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire zbtr_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output zbtr_pkg::t_out_item      o_out_item,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_idx,
    input  wire logic [15:0]         i_cfg_data
);

    localparam int F     = ANGLE_FRAC_BITS;
    localparam int R     = DEPTH_FRAC_BITS;
    localparam int CELLS = COLUMNS * ROWS;
    localparam int IW    = $clog2(CELLS);
    localparam int W     = (F < 14) ? 24 + 3 * (14 - F) : 24;
    localparam int BW0   = (F + 3 > 18) ? F + 3 : 18;
    localparam int BW    = (R + 1 > BW0) ? R + 1 : BW0;
    localparam int PW    = W + BW;
    localparam int SW    = PW + 8;
    localparam int QB    = $clog2(ROWS);
    localparam int RW    = QB + 20;
    localparam int DW    = 1 + R + 4;
    localparam int DS    = IW + $clog2(COLUMNS);
    localparam int KW    = IW + 2;

    localparam logic [KW-1:0] ROW_K = KW'(((1 << DS) + COLUMNS - 1) / COLUMNS);
    localparam logic signed [BW-1:0] TUBE_OFS =
        BW'(zbtr_pkg::TUBE_OFFSET) << F;
    localparam logic signed [W-1:0] VIEW_OFS =
        W'(zbtr_pkg::VIEW_DIST) << F;
    localparam logic signed [SW-1:0] X_OFS = SW'(zbtr_pkg::X_CENTER) << (F + R);
    localparam logic signed [SW-1:0] Y_OFS = SW'(zbtr_pkg::Y_CENTER) << (F + R);
    localparam logic signed [SW-1:0] T_BIAS = (SW'(1) << (F + R)) - SW'(1);

    typedef enum logic [3:0] {
        ST_SWEEP, ST_IDLE, ST_MUL, ST_DIV, ST_DMUL, ST_POS,
        ST_ADDR, ST_CMP, ST_RCOL, ST_RCHR, ST_OUT
    } t_state;

    t_state                r_state;
    logic [4:0]            r_step;
    zbtr_pkg::t_in_item    r_item;
    logic signed [15:0]    r_ac, r_as, r_bc, r_bs;
    logic signed [PW-1:0]  r_prod;
    logic signed [W-1:0]   r_rsh, r_rch, r_acc, r_p2, r_p4, r_t, r_xt, r_yt, r_rst, r_n;
    logic signed [W-1:0]   r_den;
    logic [R-1:0]          r_d;
    logic signed [PW-1:0]  r_px;
    logic signed [SW-1:0]  r_x, r_y;
    logic [3:0]            r_shade;
    logic [IW-1:0]         r_addr;
    logic [IW-1:0]         r_sweep;
    logic                  r_sweep_item;
    logic [RW-1:0]         r_rem;
    zbtr_pkg::t_out_item   r_res;
    logic                  r_out_valid;
    zbtr_pkg::t_out_item   r_out_item;

    logic signed [W-1:0]   mul_a;
    logic signed [BW-1:0]  mul_b;
    logic signed [PW-1:0]  prod_sh;
    logic signed [W-1:0]   mq;
    logic signed [BW-1:0]  h;
    logic                  div_start;
    logic                  div_done;
    logic [R-1:0]          div_quo;
    logic signed [SW-1:0]  sum_x, sum_y, q_x, q_y;
    logic signed [W+2:0]   n8;
    logic signed [W+2:0]   n8s;
    logic [3:0]            shade;
    logic                  x_ok, y_ok;
    logic [IW-1:0]         plot_idx;
    logic                  mem_we, mem_re;
    logic [IW-1:0]         mem_waddr, mem_raddr;
    logic [DW-1:0]         mem_wdata, mem_rdata;
    logic                  cell_fresh;
    logic [R-1:0]          cell_depth;
    logic [3:0]            cell_shade;
    logic [IW+10:0]        ci_wide;
    logic                  ci_in;
    logic [IW+KW-1:0]      row_prod;
    logic                  accept;

    assign accept = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item = r_out_item;

    assign h       = BW'($signed(r_item.tube_cos)) + TUBE_OFS;
    assign prod_sh = r_prod >>> F;
    assign mq      = prod_sh[W-1:0];

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == ST_MUL) begin
            case (r_step)
                5'd0: begin mul_a = W'($signed(r_item.ring_sin)); mul_b = h; end
                5'd1: begin mul_a = W'($signed(r_item.ring_cos)); mul_b = h; end
                5'd2: begin mul_a = r_rsh; mul_b = BW'(r_as); end
                5'd3: begin mul_a = W'($signed(r_item.tube_sin)); mul_b = BW'(r_ac); end
                5'd4: begin mul_a = r_rsh; mul_b = BW'(r_ac); end
                5'd5: begin mul_a = W'($signed(r_item.tube_sin)); mul_b = BW'(r_as); end
                5'd6: begin
                    mul_a = W'($signed(r_item.ring_sin));
                    mul_b = BW'($signed(r_item.tube_cos));
                end
                5'd7: begin mul_a = r_rch; mul_b = BW'(r_bc); end
                5'd8: begin mul_a = r_t; mul_b = BW'(r_bs); end
                5'd9: begin mul_a = r_rch; mul_b = BW'(r_bs); end
                5'd10: begin mul_a = r_t; mul_b = BW'(r_bc); end
                5'd11: begin mul_a = r_rst; mul_b = BW'(r_ac); end
                5'd12: begin mul_a = r_rst; mul_b = BW'(r_as); end
                5'd13: begin mul_a = r_acc; mul_b = BW'(r_bc); end
                5'd14: begin
                    mul_a = W'($signed(r_item.ring_cos));
                    mul_b = BW'($signed(r_item.tube_cos));
                end
                5'd15: begin mul_a = mq; mul_b = BW'(r_bs); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (r_state == ST_DMUL) begin
            mul_a = (r_step == 5'd0) ? r_xt : r_yt;
            mul_b = $signed({{(BW - R){1'b0}}, r_d});
        end
    end

    // position: truncate toward zero on the exact sum
    always_comb begin
        sum_x = X_OFS + (SW'(r_px) <<< 5) - (SW'(r_px) <<< 1);
        sum_y = Y_OFS + (SW'(r_prod) <<< 4) - SW'(r_prod);
        q_x   = (sum_x + (sum_x[SW-1] ? T_BIAS : SW'(0))) >>> (F + R);
        q_y   = (sum_y + (sum_y[SW-1] ? T_BIAS : SW'(0))) >>> (F + R);
        n8    = {r_n, 3'b000};
        n8s   = n8 >>> F;
        if (r_n[W-1]) begin
            shade = 4'd0;
        end else if (n8s > (W + 3)'(zbtr_pkg::SHADE_MAX)) begin
            shade = 4'(zbtr_pkg::SHADE_MAX);
        end else begin
            shade = n8s[3:0];
        end
    end

    assign x_ok     = !r_x[SW-1] && (r_x < SW'(COLUMNS - 1));
    assign y_ok     = !r_y[SW-1] && (r_y < SW'(ROWS));
    assign plot_idx = IW'(r_x) + IW'(COLUMNS) * IW'(r_y);

    assign ci_wide  = (IW + 11)'(i_in_item.cell_index);
    assign ci_in    = (RW'(r_item.cell_index) < RW'(CELLS));
    // row by reciprocal multiply, exact for any index inside the frame
    assign row_prod = (IW + KW)'(r_item.cell_index) * (IW + KW)'(ROW_K);

    assign cell_fresh = mem_rdata[DW-1];
    assign cell_depth = mem_rdata[R+3:4];
    assign cell_shade = mem_rdata[3:0];

    assign div_start = (r_state == ST_MUL) && (r_step == 5'd16) && !r_den[W-1]
        && (r_den != '0);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = {1'b1, r_d, r_shade};
        if (r_state == ST_SWEEP) begin
            mem_we    = 1'b1;
            mem_waddr = r_sweep;
            mem_wdata = '0;
        end else if (r_state == ST_CMP) begin
            mem_we = !(cell_fresh && (cell_depth >= r_d));
        end
        mem_re    = 1'b0;
        mem_raddr = plot_idx;
        if (accept && (i_in_item.mode == zbtr_pkg::MODE_READ)) begin
            mem_re    = 1'b1;
            mem_raddr = ci_wide[IW-1:0];
        end else if ((r_state == ST_ADDR) && x_ok && y_ok) begin
            mem_re = 1'b1;
        end
    end

    zbtr_store #(.DEPTH(CELLS), .AW(IW), .DW(DW)) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    zbtr_div #(.W(W), .F(F), .R(R)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_sweep      <= '0;
            r_sweep_item <= 1'b0;
            r_step       <= '0;
            r_out_valid  <= 1'b0;
            r_ac         <= 16'sd1 <<< F;
            r_as         <= '0;
            r_bc         <= 16'sd1 <<< F;
            r_bs         <= '0;
        end else begin
            r_prod <= mul_a * mul_b;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    zbtr_pkg::CFG_ROT_A_COS: r_ac <= i_cfg_data;
                    zbtr_pkg::CFG_ROT_A_SIN: r_as <= i_cfg_data;
                    zbtr_pkg::CFG_ROT_B_COS: r_bc <= i_cfg_data;
                    zbtr_pkg::CFG_ROT_B_SIN: r_bs <= i_cfg_data;
                    default: r_bs <= r_bs;
                endcase
            end
            if (r_out_valid && !i_out_stall && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_SWEEP: begin
                    r_sweep <= r_sweep + IW'(1);
                    if (r_sweep == IW'(CELLS - 1)) begin
                        r_res   <= '0;
                        r_state <= r_sweep_item ? ST_OUT : ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_item <= i_in_item;
                        r_step <= '0;
                        r_res  <= '0;
                        case (i_in_item.mode)
                            zbtr_pkg::MODE_CLEAR: begin
                                r_sweep      <= '0;
                                r_sweep_item <= 1'b1;
                                r_state      <= ST_SWEEP;
                            end
                            zbtr_pkg::MODE_PLOT: r_state <= ST_MUL;
                            zbtr_pkg::MODE_READ: r_state <= ST_RCOL;
                            default: r_state <= ST_OUT;
                        endcase
                    end
                end
                ST_MUL: begin
                    r_step <= r_step + 5'd1;
                    case (r_step)
                        5'd1:  r_rsh <= mq;
                        5'd2:  r_rch <= mq;
                        5'd3:  r_acc <= mq;
                        5'd4: begin
                            r_p2  <= mq;
                            r_den <= r_acc + mq + VIEW_OFS;
                        end
                        5'd5:  r_acc <= mq;
                        5'd6: begin
                            r_p4 <= mq;
                            r_t  <= r_acc - mq;
                        end
                        5'd7:  r_rst <= mq;
                        5'd8:  r_acc <= mq;
                        5'd9:  r_xt  <= r_acc - mq;
                        5'd10: r_acc <= mq;
                        5'd11: r_yt  <= r_acc + mq;
                        5'd12: r_acc <= r_p4 - mq;
                        5'd13: r_n   <= -mq - r_p2;
                        5'd14: r_n   <= r_n + mq;
                        5'd16: begin
                            r_n     <= r_n - mq;
                            r_state <= div_start ? ST_DIV : ST_OUT;
                        end
                        default: r_n <= r_n;
                    endcase
                end
                ST_DIV: begin
                    r_step <= '0;
                    if (div_done) begin
                        r_d     <= div_quo;
                        r_state <= ST_DMUL;
                    end
                end
                ST_DMUL: begin
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd1) begin
                        r_px <= r_prod;
                    end
                    if (r_step == 5'd2) begin
                        r_state <= ST_POS;
                    end
                end
                ST_POS: begin
                    // r_prod holds the y product here
                    r_x     <= q_x;
                    r_y     <= q_y;
                    r_shade <= shade;
                    r_state <= ST_ADDR;
                end
                ST_ADDR: begin
                    r_addr  <= plot_idx;
                    r_state <= (x_ok && y_ok) ? ST_CMP : ST_OUT;
                end
                ST_CMP: begin
                    r_res.plotted <= mem_we;
                    r_state       <= ST_OUT;
                end
                ST_RCOL: begin
                    r_rem   <= RW'(row_prod >> DS);
                    r_state <= ST_RCHR;
                end
                ST_RCHR: begin
                    if (!ci_in) begin
                        r_res.char_code <= zbtr_pkg::CHAR_NONE;
                    end else if (RW'(r_item.cell_index)
                                 == r_rem * RW'(COLUMNS) + RW'(COLUMNS - 1)) begin
                        r_res.char_code <= zbtr_pkg::CHAR_NEWLINE;
                    end else if (cell_fresh) begin
                        r_res.char_code <= zbtr_pkg::shade_char(cell_shade);
                    end else begin
                        r_res.char_code <= zbtr_pkg::CHAR_SPACE;
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    // hold until the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_item   <= r_res;
                        r_sweep_item <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: src/zbtr_store.sv
`default_nettype none
module zbtr_store #(
    parameter int DEPTH = 1760,
    parameter int AW    = 11,
    parameter int DW    = 21
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: src/zbtr_div.sv
`default_nettype none
module zbtr_div #(
    parameter int W = 24,
    parameter int F = 14,
    parameter int R = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic signed [W-1:0] i_den,
    output logic                     o_done,
    output logic         [R-1:0]     o_quo
);

    localparam int CW = $clog2(R + 1);
    localparam logic [W:0] ONE = (W + 1)'(1) << F;

    logic [W:0]    r_den;
    logic [W:0]    r_rem;
    logic [R-1:0]  r_quo;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W:0]    rem2;
    logic [W:0]    den_ext;

    assign rem2    = {r_rem[W-1:0], 1'b0};
    assign den_ext = {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_start) begin
                r_den <= den_ext;
                // a denominator at or below one saturates the quotient
                if (den_ext <= ONE) begin
                    r_quo  <= '1;
                    r_done <= 1'b1;
                end else begin
                    r_quo  <= '0;
                    r_rem  <= ONE;
                    r_cnt  <= CW'(R);
                    r_busy <= 1'b1;
                    r_done <= 1'b0;
                end
            end else if (r_busy) begin
                if (rem2 >= r_den) begin
                    r_rem <= rem2 - r_den;
                    r_quo <= {r_quo[R-2:0], 1'b1};
                end else begin
                    r_rem <= rem2;
                    r_quo <= {r_quo[R-2:0], 1'b0};
                end
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_done <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
`default_nettype wire
